>>> src/gvj_pkg.sv
// Shared constants, codes and types of the grid vector Jacobian stencil.
`default_nettype none

package gvj_pkg;

  // Default grid geometry and sample width
  localparam int R_POINTS_DEF    = 16;
  localparam int PHI_POINTS_DEF  = 64;
  localparam int Z_POINTS_DEF    = 16;
  localparam int SAMPLE_BITS_DEF = 24;

  // Fixed port field widths
  localparam int R_IDX_W   = 4;
  localparam int PHI_IDX_W = 6;
  localparam int Z_IDX_W   = 4;
  localparam int FIELD_W   = 24;
  localparam int DERIV_W   = 32;
  localparam int SCALE_W   = 24;
  localparam int FRAC_BITS = 16;
  localparam int CFG_IDX_W = 2;

  // Scale registers reset to 1.0 in 8.16 fixed point
  localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65536;

  // Register indexes; also used as axis codes (r, phi, z)
  localparam logic [CFG_IDX_W-1:0] CFG_INV_DR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_DPHI = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_DZ   = 2'd2;

  // Request kinds
  localparam logic REQ_STORE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Read slots of one query: centre, then near and far neighbour per axis
  localparam logic [2:0] SLOT_CENTRE   = 3'd0;
  localparam logic [2:0] SLOT_R_NEAR   = 3'd1;
  localparam logic [2:0] SLOT_R_FAR    = 3'd2;
  localparam logic [2:0] SLOT_PHI_NEAR = 3'd3;
  localparam logic [2:0] SLOT_PHI_FAR  = 3'd4;
  localparam logic [2:0] SLOT_Z_NEAR   = 3'd5;
  localparam logic [2:0] SLOT_Z_FAR    = 3'd6;
  localparam logic [2:0] READ_DRAIN    = 3'd7;
  localparam logic [2:0] CALC_LAST     = 3'd3;

  localparam logic [2:0] SLOT_NEAR [3] = '{SLOT_R_NEAR, SLOT_PHI_NEAR, SLOT_Z_NEAR};
  localparam logic [2:0] SLOT_FAR  [3] = '{SLOT_R_FAR,  SLOT_PHI_FAR,  SLOT_Z_FAR};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_DONE
  } gvj_state_e;

endpackage

`default_nettype wire

>>> src/gvj_if.sv
// Handshake channels: request input, Jacobian output and register writes.
`default_nettype none

interface gvj_req_if import gvj_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic        [R_IDX_W-1:0]   r_index;
  logic        [PHI_IDX_W-1:0] phi_index;
  logic        [Z_IDX_W-1:0]   z_index;
  logic signed [FIELD_W-1:0]   field_r;
  logic signed [FIELD_W-1:0]   field_phi;
  logic signed [FIELD_W-1:0]   field_z;

  modport source (
    output valid, req_type, r_index, phi_index, z_index, field_r, field_phi, field_z,
    input  ready
  );
  modport sink (
    input  valid, req_type, r_index, phi_index, z_index, field_r, field_phi, field_z,
    output ready
  );
endinterface

interface gvj_jac_if import gvj_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [DERIV_W-1:0] dfr_dr;
  logic signed [DERIV_W-1:0] dfr_dphi;
  logic signed [DERIV_W-1:0] dfr_dz;
  logic signed [DERIV_W-1:0] dfphi_dr;
  logic signed [DERIV_W-1:0] dfphi_dphi;
  logic signed [DERIV_W-1:0] dfphi_dz;
  logic signed [DERIV_W-1:0] dfz_dr;
  logic signed [DERIV_W-1:0] dfz_dphi;
  logic signed [DERIV_W-1:0] dfz_dz;

  modport source (
    output valid, dfr_dr, dfr_dphi, dfr_dz, dfphi_dr, dfphi_dphi, dfphi_dz,
           dfz_dr, dfz_dphi, dfz_dz,
    input  ready
  );
  modport sink (
    input  valid, dfr_dr, dfr_dphi, dfr_dz, dfphi_dr, dfphi_dphi, dfphi_dz,
           dfz_dr, dfz_dphi, dfz_dz,
    output ready
  );
endinterface

interface gvj_cfg_if import gvj_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [SCALE_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> src/gvj_store.sv
// Single-port sample store with registered read data.
`default_nettype none

module gvj_store import gvj_pkg::*; #(
  parameter int DEPTH = R_POINTS_DEF * PHI_POINTS_DEF * Z_POINTS_DEF,
  parameter int WIDTH = 3 * SAMPLE_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One access a cycle: write, or read whose data is registered for the next cycle
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> src/gvj_scale.sv
// Stencil numerator times axis scale, floor shift and 32-bit saturation.
`default_nettype none

module gvj_scale import gvj_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic signed [SAMPLE_BITS+3:0] num_i,
  input  wire logic        [SCALE_W-1:0]   scale_i,
  output logic      signed [DERIV_W-1:0]   deriv_o
);

  localparam int NUM_W  = SAMPLE_BITS + 4;
  localparam int PROD_W = NUM_W + SCALE_W + 1;
  localparam int Q_W    = PROD_W - FRAC_BITS;
  localparam int CMP_W  = (Q_W > DERIV_W) ? Q_W : DERIV_W + 1;

  localparam logic signed [DERIV_W-1:0] D_MAX = $signed({1'b0, {(DERIV_W-1){1'b1}}});
  localparam logic signed [DERIV_W-1:0] D_MIN = $signed({1'b1, {(DERIV_W-1){1'b0}}});
  localparam logic signed [CMP_W-1:0]   SAT_MAX = CMP_W'(D_MAX);
  localparam logic signed [CMP_W-1:0]   SAT_MIN = CMP_W'(D_MIN);

  logic signed [PROD_W-1:0] prod_q;
  logic signed [Q_W-1:0]    quot;
  logic signed [CMP_W-1:0]  quot_ext;

  // Registered product; scale is unsigned so it gets a zero sign bit
  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(num_i) * PROD_W'($signed({1'b0, scale_i}));
  end

  // Arithmetic shift floors toward minus infinity
  assign quot     = $signed(prod_q[PROD_W-1:FRAC_BITS]);
  assign quot_ext = CMP_W'(quot);

  always_comb begin
    if (quot_ext > SAT_MAX) begin
      deriv_o = D_MAX;
    end else if (quot_ext < SAT_MIN) begin
      deriv_o = D_MIN;
    end else begin
      deriv_o = DERIV_W'(quot_ext);
    end
  end

endmodule

`default_nettype wire

>>> src/grid_vector_jacobian_stencil.sv
// Top level: 3D three-component field store and finite-difference Jacobian.
// A store beat is written straight into the store. A query reads seven samples
// through the single store port (one a cycle), then three shared multipliers
// scale one axis a cycle; the next beat is taken once the result is loaded
// into the output register. An out-of-range query skips the reads and gives zeros.
// Reset sets the scale registers to 1.0; store contents stay undefined.
`default_nettype none

module grid_vector_jacobian_stencil import gvj_pkg::*; #(
  parameter int R_POINTS    = R_POINTS_DEF,
  parameter int PHI_POINTS  = PHI_POINTS_DEF,
  parameter int Z_POINTS    = Z_POINTS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  gvj_req_if.sink    req_i,
  gvj_jac_if.source  jac_o,
  gvj_cfg_if.sink    cfg_i
);

  localparam int GRID       = R_POINTS * PHI_POINTS * Z_POINTS;
  localparam int ADDR_W     = $clog2(GRID);
  localparam int ENTRY_W    = 3 * SAMPLE_BITS;
  localparam int NUM_W      = SAMPLE_BITS + 4;
  localparam int STRIDE_Z   = 1;
  localparam int STRIDE_PHI = Z_POINTS;
  localparam int STRIDE_R   = PHI_POINTS * Z_POINTS;

  localparam logic [ADDR_W-1:0] OFS1 [3] = '{ADDR_W'(STRIDE_R), ADDR_W'(STRIDE_PHI),
                                             ADDR_W'(STRIDE_Z)};
  localparam logic [ADDR_W-1:0] OFS2 [3] = '{ADDR_W'(2 * STRIDE_R), ADDR_W'(2 * STRIDE_PHI),
                                             ADDR_W'(2 * STRIDE_Z)};

  gvj_state_e state_q, state_d;
  logic [2:0] step_q, step_d;

  logic [SCALE_W-1:0] inv_dr_q, inv_dphi_q, inv_dz_q;

  logic              req_acc, req_ok;
  logic [ADDR_W-1:0] req_addr;
  logic [2:0]        req_lo, req_hi;

  logic [ADDR_W-1:0] centre_q;
  logic [2:0]        lo_q, hi_q;
  logic              bad_q;

  logic               mem_en, mem_we;
  logic [ADDR_W-1:0]  mem_addr, nbr_addr;
  logic [ENTRY_W-1:0] mem_wdata, mem_rdata;

  logic       rd_vld_q;
  logic [2:0] rd_slot_q;

  logic signed [NUM_W-1:0]   rd_f   [3];
  logic signed [NUM_W-1:0]   acc_q  [3][3];
  logic        [SCALE_W-1:0] scale;
  logic signed [DERIV_W-1:0] deriv  [3];
  logic signed [DERIV_W-1:0] jac_q  [3][3];
  logic signed [DERIV_W-1:0] out_q  [3][3];
  logic                      out_vld_q;
  logic                      load_out;
  logic [1:0]                wr_axis;

  // Configuration registers, always ready
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_dr_q   <= SCALE_RESET;
      inv_dphi_q <= SCALE_RESET;
      inv_dz_q   <= SCALE_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_INV_DR:   inv_dr_q   <= cfg_i.data;
        CFG_INV_DPHI: inv_dphi_q <= cfg_i.data;
        CFG_INV_DZ:   inv_dz_q   <= cfg_i.data;
        default:      ;
      endcase
    end
  end

  // Request decode: range check, grid address and edge flags
  assign req_acc = req_i.valid && req_i.ready;
  assign req_ok  = (32'(req_i.r_index) < 32'(R_POINTS)) &&
                   (32'(req_i.phi_index) < 32'(PHI_POINTS)) &&
                   (32'(req_i.z_index) < 32'(Z_POINTS));
  assign req_addr = ADDR_W'(32'(req_i.r_index) * 32'(STRIDE_R) +
                            32'(req_i.phi_index) * 32'(STRIDE_PHI) + 32'(req_i.z_index));
  assign req_lo = {req_i.z_index == '0, req_i.phi_index == '0, req_i.r_index == '0};
  assign req_hi = {32'(req_i.z_index) == 32'(Z_POINTS - 1),
                   32'(req_i.phi_index) == 32'(PHI_POINTS - 1),
                   32'(req_i.r_index) == 32'(R_POINTS - 1)};

  // Samples wrapped to the stored width
  assign mem_wdata = {SAMPLE_BITS'(req_i.field_z), SAMPLE_BITS'(req_i.field_phi),
                      SAMPLE_BITS'(req_i.field_r)};

  always_ff @(posedge clk_i) begin
    if (req_acc && req_i.req_type == REQ_QUERY) begin
      centre_q <= req_addr;
      lo_q     <= req_lo;
      hi_q     <= req_hi;
      bad_q    <= !req_ok;
    end
  end

  // Neighbour address of the current read slot
  always_comb begin
    nbr_addr = centre_q;
    for (int a = 0; a < 3; a++) begin
      if (step_q == SLOT_NEAR[a]) begin
        nbr_addr = hi_q[a] ? centre_q - OFS1[a] : centre_q + OFS1[a];
      end else if (step_q == SLOT_FAR[a]) begin
        if (lo_q[a]) begin
          nbr_addr = centre_q + OFS2[a];
        end else if (hi_q[a]) begin
          nbr_addr = centre_q - OFS2[a];
        end else begin
          nbr_addr = centre_q - OFS1[a];
        end
      end
    end
  end

  // Sequencer: next state
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      ST_IDLE: begin
        step_d = '0;
        if (req_acc && req_i.req_type == REQ_QUERY) begin
          state_d = req_ok ? ST_READ : ST_DONE;
        end
      end
      ST_READ: begin
        step_d = step_q + 3'd1;
        if (step_q == READ_DRAIN) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        step_d = step_q + 3'd1;
        if (step_q == CALC_LAST) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer: outputs; ready is high throughout idle, so there valid alone marks a beat
  always_comb begin
    req_i.ready = 1'b0;
    mem_en      = 1'b0;
    mem_we      = 1'b0;
    mem_addr    = nbr_addr;
    load_out    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid && req_i.req_type == REQ_STORE && req_ok) begin
          mem_en   = 1'b1;
          mem_we   = 1'b1;
          mem_addr = req_addr;
        end
      end
      ST_READ: mem_en   = (step_q != READ_DRAIN);
      ST_CALC: ;
      ST_DONE: load_out = !out_vld_q || jac_o.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      step_q    <= '0;
      rd_vld_q  <= 1'b0;
      rd_slot_q <= '0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      rd_vld_q  <= mem_en && !mem_we;
      rd_slot_q <= step_q;
    end
  end

  gvj_store #(
    .DEPTH (GRID),
    .WIDTH (ENTRY_W)
  ) u_store (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // Returned sample, one component per lane
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rd_f[c] = NUM_W'($signed(mem_rdata[c*SAMPLE_BITS +: SAMPLE_BITS]));
    end
  end

  // Stencil accumulation as samples return; shift one axis out per cycle
  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      for (int a = 0; a < 3; a++) begin
        for (int c = 0; c < 3; c++) begin
          if (rd_slot_q == SLOT_CENTRE) begin
            if (lo_q[a]) begin
              acc_q[a][c] <= -((rd_f[c] <<< 1) + rd_f[c]);
            end else if (hi_q[a]) begin
              acc_q[a][c] <= (rd_f[c] <<< 1) + rd_f[c];
            end else begin
              acc_q[a][c] <= '0;
            end
          end else if (rd_slot_q == SLOT_NEAR[a]) begin
            if (lo_q[a]) begin
              acc_q[a][c] <= acc_q[a][c] + (rd_f[c] <<< 2);
            end else if (hi_q[a]) begin
              acc_q[a][c] <= acc_q[a][c] - (rd_f[c] <<< 2);
            end else begin
              acc_q[a][c] <= acc_q[a][c] + rd_f[c];
            end
          end else if (rd_slot_q == SLOT_FAR[a]) begin
            acc_q[a][c] <= hi_q[a] ? acc_q[a][c] + rd_f[c] : acc_q[a][c] - rd_f[c];
          end
        end
      end
    end else if (state_q == ST_CALC) begin
      acc_q[0] <= acc_q[1];
      acc_q[1] <= acc_q[2];
    end
  end

  // Scale of the axis at the head of the accumulator line
  always_comb begin
    case (step_q[1:0])
      CFG_INV_DR:   scale = inv_dr_q;
      CFG_INV_DPHI: scale = inv_dphi_q;
      default:      scale = inv_dz_q;
    endcase
  end

  for (genvar c = 0; c < 3; c++) begin : g_lane
    gvj_scale #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scale (
      .clk_i   (clk_i),
      .num_i   (acc_q[0][c]),
      .scale_i (scale),
      .deriv_o (deriv[c])
    );
  end

  // Products land in the cycle after their axis was issued
  assign wr_axis = 2'(step_q - 3'd1);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CALC && step_q != '0) begin
      for (int c = 0; c < 3; c++) begin
        jac_q[c][wr_axis] <= deriv[c];
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      for (int c = 0; c < 3; c++) begin
        for (int a = 0; a < 3; a++) begin
          out_q[c][a] <= bad_q ? '0 : jac_q[c][a];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load_out) begin
      out_vld_q <= 1'b1;
    end else if (jac_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  assign jac_o.valid      = out_vld_q;
  assign jac_o.dfr_dr     = out_q[0][0];
  assign jac_o.dfr_dphi   = out_q[0][1];
  assign jac_o.dfr_dz     = out_q[0][2];
  assign jac_o.dfphi_dr   = out_q[1][0];
  assign jac_o.dfphi_dphi = out_q[1][1];
  assign jac_o.dfphi_dz   = out_q[1][2];
  assign jac_o.dfz_dr     = out_q[2][0];
  assign jac_o.dfz_dphi   = out_q[2][1];
  assign jac_o.dfz_dz     = out_q[2][2];

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking bench for the grid vector Jacobian stencil: store and query traffic, scale sweeps.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import gvj_pkg::*;

  localparam int GRID_R      = R_POINTS_DEF;
  localparam int GRID_PHI    = PHI_POINTS_DEF;
  localparam int GRID_Z      = Z_POINTS_DEF;
  localparam int GRID_POINTS = GRID_R * GRID_PHI * GRID_Z;
  localparam int N_TERMS     = 9;

  // Leave some margin after the last result before touching registers
  localparam int SETTLE_CYCLES = 24;
  localparam int PHASE_ITEMS   = 245;
  localparam int LIMIT_NS      = 1_000_000;

  // Index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  localparam logic signed [FIELD_W-1:0] FIELD_MIN = {1'b1, {(FIELD_W-1){1'b0}}};
  localparam logic signed [FIELD_W-1:0] FIELD_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
  localparam logic [SCALE_W-1:0]        SCALE_MAX = {SCALE_W{1'b1}};

  // Fill patterns for a query neighbourhood
  localparam int FILL_RANDOM    = 0;
  localparam int FILL_PEAK_UP   = 1;
  localparam int FILL_PEAK_DOWN = 2;

  // Receiver stall modes
  localparam int RX_OPEN   = 0;
  localparam int RX_COIN   = 1;
  localparam int RX_PULSE  = 2;
  localparam int RX_SPARSE = 3;

  typedef struct packed {
    logic                        req_type;
    logic        [R_IDX_W-1:0]   r_index;
    logic        [PHI_IDX_W-1:0] phi_index;
    logic        [Z_IDX_W-1:0]   z_index;
    logic signed [FIELD_W-1:0]   field_r;
    logic signed [FIELD_W-1:0]   field_phi;
    logic signed [FIELD_W-1:0]   field_z;
  } req_item_t;

  // Nine terms, term c*3+a at slice c*3+a (component c along axis a)
  typedef logic [N_TERMS*DERIV_W-1:0] jac_vec_t;

  logic clk_i;
  logic rst_ni;

  gvj_req_if req_if ();
  gvj_jac_if jac_if ();
  gvj_cfg_if cfg_if ();

  grid_vector_jacobian_stencil uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .jac_o  (jac_if),
    .cfg_i  (cfg_if)
  );

  // Pending beats, expected Jacobians and the shadow of the block's state
  req_item_t             pending_items [$];
  jac_vec_t              expected_jac [$];
  logic [3*FIELD_W-1:0]  sample_store [GRID_POINTS];
  bit                    planned [GRID_POINTS];
  logic [SCALE_W-1:0]    axis_scale [3];

  bit req_beat;
  int items_planned;
  int failures;
  int store_beats;
  int query_beats;
  int jacobians_checked;
  int saturated_terms;
  int cfg_writes;
  int scale_settings;

  int burst_left;
  int gap_left;
  int stall_mode;
  int stall_left;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Grid helpers
  function automatic int grid_addr(input int r, input int p, input int z);
    grid_addr = (r * GRID_PHI + p) * GRID_Z + z;
  endfunction

  function automatic int axis_size(input int axis);
    case (axis)
      CFG_INV_DR:   axis_size = GRID_R;
      CFG_INV_DPHI: axis_size = GRID_PHI;
      default:      axis_size = GRID_Z;
    endcase
  endfunction

  // First neighbour of the stencil: forward at index 0, backward at the last
  function automatic int near_pos(input int pos, input int size);
    if (pos == 0) near_pos = 1;
    else if (pos == size - 1) near_pos = size - 2;
    else near_pos = pos + 1;
  endfunction

  // Second neighbour: two away at the edges, the opposite side inside
  function automatic int far_pos(input int pos, input int size);
    if (pos == 0) far_pos = 2;
    else if (pos == size - 1) far_pos = size - 3;
    else far_pos = pos - 1;
  endfunction

  function automatic longint sample_at(input int r, input int p, input int z, input int c);
    logic [3*FIELD_W-1:0]      entry;
    logic signed [FIELD_W-1:0] comp;
    entry = sample_store[grid_addr(r, p, z)];
    comp = entry[c*FIELD_W +: FIELD_W];
    sample_at = comp;
  endfunction

  // Stencil numerator for component c along one axis
  function automatic longint stencil_num(input int r, input int p, input int z,
                                         input int axis, input int c);
    int     cn [3];
    int     cf [3];
    int     size;
    longint f0, fn, ff;
    cn = '{r, p, z};
    cf = cn;
    size = axis_size(axis);
    cn[axis] = near_pos(cn[axis], size);
    cf[axis] = far_pos(cf[axis], size);
    f0 = sample_at(r, p, z, c);
    fn = sample_at(cn[0], cn[1], cn[2], c);
    ff = sample_at(cf[0], cf[1], cf[2], c);
    if (cn[axis] == 1 && cf[axis] == 2 &&
        (axis == CFG_INV_DR ? r : axis == CFG_INV_DPHI ? p : z) == 0)
      stencil_num = -3 * f0 + 4 * fn - ff;
    else if (cn[axis] == size - 2 && cf[axis] == size - 3 &&
             (axis == CFG_INV_DR ? r : axis == CFG_INV_DPHI ? p : z) == size - 1)
      stencil_num = 3 * f0 - 4 * fn + ff;
    else
      stencil_num = fn - ff;
  endfunction

  // Scale by 8.16 fixed point, floor the shift, clip to 32 bits
  function automatic logic [DERIV_W-1:0] scale_sat(input longint num,
                                                   input logic [SCALE_W-1:0] s,
                                                   output bit clipped);
    longint prod, q;
    prod = num * longint'(s);
    q = prod >>> FRAC_BITS;
    clipped = 1'b0;
    if (q > 64'sd2147483647) begin
      q = 64'sd2147483647;
      clipped = 1'b1;
    end else if (q < -64'sd2147483648) begin
      q = -64'sd2147483648;
      clipped = 1'b1;
    end
    scale_sat = q[DERIV_W-1:0];
  endfunction

  function automatic jac_vec_t predict_jacobian(input req_item_t it);
    jac_vec_t v;
    bit       clipped;
    int       r, p, z;
    r = it.r_index;
    p = it.phi_index;
    z = it.z_index;
    v = '0;
    if (r < GRID_R && p < GRID_PHI && z < GRID_Z) begin
      for (int c = 0; c < 3; c++) begin
        for (int a = 0; a < 3; a++) begin
          v[(c*3+a)*DERIV_W +: DERIV_W] = scale_sat(stencil_num(r, p, z, a, c), axis_scale[a],
                                                    clipped);
          if (clipped) saturated_terms++;
        end
      end
    end
    predict_jacobian = v;
  endfunction

  function automatic string term_name(input int k);
    case (k)
      0:       term_name = "dfr_dr";
      1:       term_name = "dfr_dphi";
      2:       term_name = "dfr_dz";
      3:       term_name = "dfphi_dr";
      4:       term_name = "dfphi_dphi";
      5:       term_name = "dfphi_dz";
      6:       term_name = "dfz_dr";
      7:       term_name = "dfz_dphi";
      default: term_name = "dfz_dz";
    endcase
  endfunction

  // Stimulus builders
  function automatic logic signed [FIELD_W-1:0] rand_field();
    logic [31:0] raw;
    raw = $urandom;
    case ($urandom_range(0, 7))
      0:       rand_field = FIELD_MIN;
      1:       rand_field = FIELD_MAX;
      2:       rand_field = '0;
      3:       rand_field = '1;
      default: rand_field = raw[FIELD_W-1:0];
    endcase
  endfunction

  // Biased towards the edges so every stencil shows up often
  function automatic int pick_pos(input int size);
    case ($urandom_range(0, 7))
      0:       pick_pos = 0;
      1:       pick_pos = size - 1;
      2:       pick_pos = 1;
      3:       pick_pos = size - 2;
      default: pick_pos = $urandom_range(0, size - 1);
    endcase
  endfunction

  task automatic push_store(input int r, input int p, input int z,
                            input logic signed [FIELD_W-1:0] fr, fp, fz);
    req_item_t it;
    it.req_type  = REQ_STORE;
    it.r_index   = r[R_IDX_W-1:0];
    it.phi_index = p[PHI_IDX_W-1:0];
    it.z_index   = z[Z_IDX_W-1:0];
    it.field_r   = fr;
    it.field_phi = fp;
    it.field_z   = fz;
    pending_items.push_back(it);
    planned[grid_addr(r, p, z)] = 1'b1;
    items_planned++;
  endtask

  task automatic push_query(input int r, input int p, input int z);
    req_item_t it;
    it = '0;
    it.req_type  = REQ_QUERY;
    it.r_index   = r[R_IDX_W-1:0];
    it.phi_index = p[PHI_IDX_W-1:0];
    it.z_index   = z[Z_IDX_W-1:0];
    it.field_r   = rand_field();
    it.field_phi = rand_field();
    it.field_z   = rand_field();
    pending_items.push_back(it);
    items_planned++;
  endtask

  // Write what the stencils at (r,p,z) need, then query it; slot 0 is the
  // centre, then near and far per axis
  task automatic plan_query(input int r, input int p, input int z,
                            input int style, input int refresh_pct);
    int                        c3 [3];
    int                        ax;
    logic signed [FIELD_W-1:0] fv;
    for (int slot = 0; slot < 7; slot++) begin
      c3 = '{r, p, z};
      if (slot > 0) begin
        ax = (slot - 1) / 2;
        c3[ax] = (slot % 2 == 1) ? near_pos(c3[ax], axis_size(ax)) :
                                   far_pos(c3[ax], axis_size(ax));
      end
      if (!planned[grid_addr(c3[0], c3[1], c3[2])] || $urandom_range(0, 99) < refresh_pct) begin
        if (style == FILL_RANDOM) begin
          push_store(c3[0], c3[1], c3[2], rand_field(), rand_field(), rand_field());
        end else begin
          fv = ((slot == 0 || slot % 2 == 0) == (style == FILL_PEAK_UP)) ? FIELD_MIN : FIELD_MAX;
          push_store(c3[0], c3[1], c3[2], fv, fv, fv);
        end
      end
    end
    push_query(r, p, z);
  endtask

  task automatic random_traffic(input int count);
    int stop_at;
    int style;
    stop_at = items_planned + count;
    while (items_planned < stop_at) begin
      if ($urandom_range(0, 99) < 85) begin
        case ($urandom_range(0, 9))
          0:       style = FILL_PEAK_UP;
          1:       style = FILL_PEAK_DOWN;
          default: style = FILL_RANDOM;
        endcase
        plan_query(pick_pos(GRID_R), pick_pos(GRID_PHI), pick_pos(GRID_Z), style, 25);
      end else begin
        // loose stores that no query follows straight away
        repeat ($urandom_range(1, 3))
          push_store($urandom_range(0, GRID_R - 1), $urandom_range(0, GRID_PHI - 1),
                     $urandom_range(0, GRID_Z - 1), rand_field(), rand_field(), rand_field());
      end
    end
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || req_if.valid || expected_jac.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SCALE_W-1:0] value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    cfg_writes++;
  endtask

  task automatic set_scales(input logic [SCALE_W-1:0] s_r, s_phi, s_z);
    write_reg(CFG_INV_DR, s_r);
    write_reg(CFG_INV_DPHI, s_phi);
    write_reg(CFG_INV_DZ, s_z);
    scale_settings++;
  endtask

  // Request driver: bursts of beats with random gaps in between
  always @(negedge clk_i) begin
    req_item_t it;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_beat) begin
      if (gap_left > 0 || pending_items.size() == 0) begin
        req_if.valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        it = pending_items.pop_front();
        req_if.valid     <= 1'b1;
        req_if.req_type  <= it.req_type;
        req_if.r_index   <= it.r_index;
        req_if.phi_index <= it.phi_index;
        req_if.z_index   <= it.z_index;
        req_if.field_r   <= it.field_r;
        req_if.field_phi <= it.field_phi;
        req_if.field_z   <= it.field_z;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // Result receiver: stall mode is picked anew at random
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      jac_if.ready <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(RX_OPEN, RX_SPARSE);
        stall_left = $urandom_range(16, 120);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        RX_OPEN:  jac_if.ready <= 1'b1;
        RX_COIN:  jac_if.ready <= 1'($urandom_range(0, 1));
        RX_PULSE: jac_if.ready <= (stall_left % 5 == 0);
        default:  jac_if.ready <= ($urandom_range(0, 24) == 0);
      endcase
    end
  end

  // Monitor: shadow registers, predict on request beats, check result beats
  always @(posedge clk_i) begin
    req_item_t it;
    jac_vec_t  got;
    jac_vec_t  want;
    req_beat = rst_ni && req_if.valid && req_if.ready;

    if (rst_ni && cfg_if.valid && cfg_if.ready) begin
      // writes to the spare index are dropped
      if (cfg_if.index <= CFG_INV_DZ) axis_scale[cfg_if.index] = cfg_if.data;
    end

    if (req_beat) begin
      it.req_type  = req_if.req_type;
      it.r_index   = req_if.r_index;
      it.phi_index = req_if.phi_index;
      it.z_index   = req_if.z_index;
      it.field_r   = req_if.field_r;
      it.field_phi = req_if.field_phi;
      it.field_z   = req_if.field_z;
      if (it.req_type == REQ_QUERY) begin
        expected_jac.push_back(predict_jacobian(it));
        query_beats++;
      end else begin
        // default sample width equals the field width, so samples keep every bit
        if (it.r_index < GRID_R && it.phi_index < GRID_PHI && it.z_index < GRID_Z)
          sample_store[grid_addr(it.r_index, it.phi_index, it.z_index)] =
            {it.field_z, it.field_phi, it.field_r};
        store_beats++;
      end
    end

    if (rst_ni && jac_if.valid && jac_if.ready) begin
      got = {jac_if.dfz_dz, jac_if.dfz_dphi, jac_if.dfz_dr,
             jac_if.dfphi_dz, jac_if.dfphi_dphi, jac_if.dfphi_dr,
             jac_if.dfr_dz, jac_if.dfr_dphi, jac_if.dfr_dr};
      if (expected_jac.size() == 0) begin
        $display("%0t: Jacobian beat with none expected, dfr_dr got %0d", $time,
                 $signed(jac_if.dfr_dr));
        failures++;
      end else begin
        want = expected_jac.pop_front();
        for (int k = 0; k < N_TERMS; k++) begin
          if (got[k*DERIV_W +: DERIV_W] !== want[k*DERIV_W +: DERIV_W]) begin
            $display("%0t: %s expected %0d, got %0d", $time, term_name(k),
                     $signed(want[k*DERIV_W +: DERIV_W]), $signed(got[k*DERIV_W +: DERIV_W]));
            failures++;
          end
        end
        jacobians_checked++;
      end
    end
  end

  // Run watchdog
  initial begin
    #(LIMIT_NS);
    $display("%0t: run did not drain in time", $time);
    $display("Some tests failed");
    $finish;
  end

  // Sequence of phases
  initial begin
    rst_ni           = 1'b0;
    req_beat         = 1'b0;
    req_if.valid     = 1'b0;
    req_if.req_type  = REQ_STORE;
    req_if.r_index   = '0;
    req_if.phi_index = '0;
    req_if.z_index   = '0;
    req_if.field_r   = '0;
    req_if.field_phi = '0;
    req_if.field_z   = '0;
    jac_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = CFG_INV_DR;
    cfg_if.data      = '0;
    axis_scale       = '{SCALE_RESET, SCALE_RESET, SCALE_RESET};
    burst_left       = 1;
    gap_left         = 0;
    stall_mode       = RX_OPEN;
    stall_left       = 0;
    scale_settings   = 1;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: all-forward corner, all-backward corner, mixed stencils
    plan_query(0, 0, 0, FILL_PEAK_UP, 100);
    plan_query(GRID_R - 1, GRID_PHI - 1, GRID_Z - 1, FILL_PEAK_DOWN, 100);
    plan_query(7, GRID_PHI - 1, 0, FILL_RANDOM, 100);
    wait_idle();

    // Random scales, with a write to the spare index that must be ignored
    write_reg(CFG_SPARE, SCALE_W'($urandom_range(0, SCALE_MAX)));
    set_scales(SCALE_W'($urandom_range(0, SCALE_MAX)), SCALE_W'($urandom_range(0, SCALE_MAX)),
               SCALE_W'($urandom_range(0, SCALE_MAX)));
    random_traffic(PHASE_ITEMS);
    wait_idle();

    // Largest scales drive the outputs into saturation
    set_scales(SCALE_MAX, SCALE_MAX, SCALE_MAX);
    random_traffic(PHASE_ITEMS);
    wait_idle();

    set_scales('0, '0, '0);
    random_traffic(PHASE_ITEMS);
    wait_idle();

    set_scales(SCALE_MAX, '0, SCALE_W'($urandom_range(0, SCALE_MAX)));
    random_traffic(PHASE_ITEMS);
    wait_idle();

    set_scales(SCALE_W'($urandom_range(0, 131071)), SCALE_W'($urandom_range(0, 131071)),
               SCALE_W'($urandom_range(0, 131071)));
    random_traffic(PHASE_ITEMS);
    wait_idle();

    $display("Covered %0d store beats and %0d queries; %0d Jacobians checked, %0d terms clipped",
             store_beats, query_beats, jacobians_checked, saturated_terms);
    $display("%0d register writes over %0d scale settings, %0d mismatches",
             cfg_writes, scale_settings, failures);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
